// File: rtl/g2lo_pkg.sv
// Shared types, constants and elaboration-time table functions for the offset pipeline.
package g2lo_pkg;

  // Angle fraction bits (radians in Q.32)
  localparam int ANGLE_FRAC_BITS = 32;
  localparam int TAYLOR_TERMS    = 13;
  localparam int CORDIC_STEPS    = ANGLE_FRAC_BITS + 1;
  localparam int SQRT_STEPS      = ANGLE_FRAC_BITS + 1;

  localparam logic [32:0] ONE         = 33'h1_0000_0000;
  localparam logic [32:0] HALF_TURN   = 33'd3600000000;
  localparam logic [32:0] TWO_HALF    = 33'd7200000000;
  localparam logic [32:0] QUARTER     = 33'd1800000000;
  localparam logic [30:0] SPAN_LIMIT  = 31'd2000000000;
  localparam logic [63:0] RADIUS      = 64'd63781370000;
  localparam logic [31:0] RAD_LO      = RADIUS[31:0];
  localparam logic [3:0]  RAD_HI      = RADIUS[35:32];
  localparam logic [63:0] CONV_NUM    = 64'd6283185307;
  localparam logic [63:0] CONV_DEN    = 64'd3600000000000000000;
  localparam int          CONV_SHIFT  = 91;

  typedef logic [32:0] th_t;   // angle or sine, Q.32
  typedef logic [33:0] s2_t;   // squared angle, Q.32
  typedef logic [33:0] p_t;    // Horner product, Q.32

  typedef struct packed {
    logic signed [31:0] local_east;
    logic signed [31:0] local_north;
    logic               east_pos;
    logic               north_pos;
    logic [30:0]        north_span;
  } side_t;

  // Restoring divide, elaboration only
  function automatic logic [63:0] divu(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // pi/180e7 scaled by 2^91
  function automatic logic [63:0] conv_const();
    logic [63:0] r;
    logic [63:0] q;
    r = CONV_NUM;
    q = '0;
    for (int i = 0; i < CONV_SHIFT; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= CONV_DEN) begin
        r    = r - CONV_DEN;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [63:0] CQ    = conv_const();
  localparam logic [30:0] CQ_LO = CQ[30:0];
  localparam logic [30:0] CQ_HI = CQ[61:31];

  // atan(1/n) in Q62 by series
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] k;
    p = divu(64'h4000_0000_0000_0000, n);
    s = '0;
    k = '0;
    while (p != 64'd0) begin
      term = divu(p, {k[62:0], 1'b0} + 64'd1);
      if (k[0]) s = s - term;
      else      s = s + term;
      p = divu(divu(p, n), n);
      k = k + 64'd1;
    end
    return s;
  endfunction

  // CORDIC angle of step i, Q.32
  function automatic th_t atan_q(input int i);
    logic [63:0] a62;
    if (i == 0) a62 = (atan_recip(64'd5) << 2) - atan_recip(64'd239);
    else        a62 = atan_recip(64'd1 << i);
    return th_t'((a62 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS));
  endfunction

  // Horner divisor 2k(2k+1) of term j, k counting down from TAYLOR_TERMS
  function automatic logic [9:0] horner_d(input int j);
    int k;
    k = TAYLOR_TERMS - j;
    return 10'((2 * k) * (2 * k + 1));
  endfunction

  // Reciprocal floor(2^34 / d)
  function automatic logic [31:0] horner_m(input int j);
    return 32'(divu(64'd1 << 34, 64'(horner_d(j))));
  endfunction

endpackage

// File: rtl/g2lo_front.sv
// Front end: differences, angle folding, radian conversion and north span.
module g2lo_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [30:0]   cur_lat_i,
  input  logic signed [31:0]   cur_lon_i,
  input  logic signed [30:0]   next_lat_i,
  input  logic signed [31:0]   next_lon_i,
  input  logic signed [31:0]   local_east_i,
  input  logic signed [31:0]   local_north_i,
  output logic                 valid_o,
  output g2lo_pkg::th_t [1:0]  th_o,
  output g2lo_pkg::side_t      side_o
);
  import g2lo_pkg::*;

  localparam int NF = 7;

  logic [NF-1:0] vld_q;
  side_t         side_q [NF];

  // stage 1 combinational
  logic signed [32:0] dlon;
  logic signed [31:0] dlat;
  logic [30:0]        alat;
  logic [32:0]        ang_d [3];
  side_t              side_d;

  logic [32:0]        f1_ang_q [3];
  logic [31:0]        f2_mod_q [3];
  logic [30:0]        f3_red_q [3];
  logic [61:0]        f4_ph_q  [3];
  logic [61:0]        f4_pl_q  [3];
  th_t  [1:0]         f5_th_q;
  logic [33:0]        f5_thn_q;
  th_t  [1:0]         f6_th_q;
  logic [37:0]        f6_nh_q;
  logic [65:0]        f6_nl_q;
  th_t  [1:0]         f7_th_q;

  logic [92:0]        full [3];
  logic [38:0]        nsum;
  side_t              side_last;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NF-2:0], valid_i};
    end
  end

  // differences and magnitudes
  always_comb begin
    dlon = $signed({next_lon_i[31], next_lon_i}) - $signed({cur_lon_i[31], cur_lon_i});
    dlat = $signed({next_lat_i[30], next_lat_i}) - $signed({cur_lat_i[30], cur_lat_i});
    alat = cur_lat_i[30] ? 31'(-cur_lat_i) : 31'(cur_lat_i);
    ang_d[0] = {1'b0, alat, 1'b0} + QUARTER;
    ang_d[1] = dlon[32] ? 33'(-dlon) : 33'(dlon);
    ang_d[2] = dlat[31] ? {1'b0, 32'(-dlat)} : {1'b0, 32'(dlat)};
    side_d.local_east  = local_east_i;
    side_d.local_north = local_north_i;
    side_d.east_pos    = !dlon[32] && (dlon != '0);
    side_d.north_pos   = !dlat[31] && (dlat != '0);
    side_d.north_span  = '0;
  end

  // conversion sum, north uses one less bit of shift
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      full[l] = {f4_ph_q[l], 31'b0} + 93'(f4_pl_q[l]);
    end
    nsum = 39'(f6_nh_q) + 39'((f6_nl_q + (66'd1 << 31)) >> 32);
    side_last            = side_q[NF-2];
    side_last.north_span = (nsum > 39'(SPAN_LIMIT)) ? SPAN_LIMIT : nsum[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      f1_ang_q  <= ang_d;
      side_q[0] <= side_d;
      for (int l = 0; l < 3; l++) begin
        // stage 2: modulo half turn
        if (f1_ang_q[l] >= TWO_HALF)       f2_mod_q[l] <= 32'(f1_ang_q[l] - TWO_HALF);
        else if (f1_ang_q[l] >= HALF_TURN) f2_mod_q[l] <= 32'(f1_ang_q[l] - HALF_TURN);
        else                               f2_mod_q[l] <= 32'(f1_ang_q[l]);
        // stage 3: fold to quarter turn
        if (33'(f2_mod_q[l]) > QUARTER) f3_red_q[l] <= 31'(HALF_TURN - 33'(f2_mod_q[l]));
        else                            f3_red_q[l] <= 31'(f2_mod_q[l]);
        // stage 4: partial products with the radian constant
        f4_ph_q[l] <= 62'(f3_red_q[l]) * 62'(CQ_HI);
        f4_pl_q[l] <= 62'(f3_red_q[l]) * 62'(CQ_LO);
      end
      // stage 5: round to Q.32
      for (int l = 0; l < 2; l++) begin
        f5_th_q[l] <= th_t'((full[l] + (93'd1 << 59)) >> 60);
      end
      f5_thn_q <= 34'((full[2] + (93'd1 << 58)) >> 59);
      // stage 6: north span products
      f6_th_q <= f5_th_q;
      f6_nh_q <= 38'(f5_thn_q) * 38'(RAD_HI);
      f6_nl_q <= 66'(f5_thn_q) * 66'(RAD_LO);
      // stage 7: north span rounded and saturated
      f7_th_q <= f6_th_q;
      for (int s = 1; s < NF - 1; s++) begin
        side_q[s] <= side_q[s-1];
      end
      side_q[NF-1] <= side_last;
    end
  end

  assign valid_o = vld_q[NF-1];
  assign th_o    = f7_th_q;
  assign side_o  = side_q[NF-1];

endmodule

// File: rtl/g2lo_sin.sv
// Two-lane pipelined sine over a quarter turn, Horner on the Taylor series.
module g2lo_sin (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  g2lo_pkg::th_t [1:0]  th_i,
  input  g2lo_pkg::side_t      side_i,
  output logic                 valid_o,
  output g2lo_pkg::th_t [1:0]  sin_o,
  output g2lo_pkg::side_t      side_o
);
  import g2lo_pkg::*;

  localparam int TT = TAYLOR_TERMS;

  // squaring stage
  logic              sq_vld_q;
  th_t  [1:0]        sq_th_q;
  s2_t  [1:0]        sq_s2_q;
  side_t             sq_side_q;
  logic [65:0]       sq_prod [2];

  // Horner sub-stages A (product), B (reciprocal), C (correct and subtract)
  logic [TT-1:0]     a_vld_q, b_vld_q, c_vld_q;
  th_t  [1:0]        a_th_q [TT], b_th_q [TT], c_th_q [TT];
  s2_t  [1:0]        a_s2_q [TT], b_s2_q [TT], c_s2_q [TT];
  p_t   [1:0]        a_p_q  [TT], b_p_q  [TT];
  logic [1:0][31:0]  b_q0_q [TT];
  th_t  [1:0]        c_t_q  [TT];
  side_t             a_side_q [TT], b_side_q [TT], c_side_q [TT];

  logic              in_vld  [TT];
  th_t  [1:0]        in_th   [TT];
  s2_t  [1:0]        in_s2   [TT];
  th_t  [1:0]        in_t    [TT];
  side_t             in_side [TT];

  // result stage
  logic              r_vld_q;
  th_t  [1:0]        r_sin_q;
  side_t             r_side_q;
  logic [65:0]       r_prod [2];
  logic [33:0]       r_rnd  [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sq_prod[l] = 66'(th_i[l]) * 66'(th_i[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      r_vld_q  <= 1'b0;
    end else if (en_i) begin
      sq_vld_q <= valid_i;
      r_vld_q  <= c_vld_q[TT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_th_q   <= th_i;
      sq_side_q <= side_i;
      for (int l = 0; l < 2; l++) begin
        sq_s2_q[l] <= s2_t'((sq_prod[l] + (66'd1 << 31)) >> 32);
      end
    end
  end

  genvar j;
  for (j = 0; j < TT; j++) begin : g_term
    localparam logic [9:0]  D = horner_d(j);
    localparam logic [31:0] M = horner_m(j);

    logic [66:0] pa  [2];
    logic [65:0] pb  [2];
    logic [41:0] qd  [2];
    logic [33:0] rr  [2];
    logic [31:0] qq  [2];

    if (j == 0) begin : g_first
      assign in_vld[j]  = sq_vld_q;
      assign in_th[j]   = sq_th_q;
      assign in_s2[j]   = sq_s2_q;
      assign in_t[j]    = {ONE, ONE};
      assign in_side[j] = sq_side_q;
    end else begin : g_next
      assign in_vld[j]  = c_vld_q[j-1];
      assign in_th[j]   = c_th_q[j-1];
      assign in_s2[j]   = c_s2_q[j-1];
      assign in_t[j]    = c_t_q[j-1];
      assign in_side[j] = c_side_q[j-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        pa[l] = 67'(in_s2[j][l]) * 67'(in_t[j][l]);
        pb[l] = 66'(a_p_q[j][l]) * 66'(M);
        qd[l] = 42'(b_q0_q[j][l]) * 42'(D);
        rr[l] = 34'(42'(b_p_q[j][l]) - qd[l]);
        qq[l] = (rr[l] >= 34'(D)) ? b_q0_q[j][l] + 32'd1 : b_q0_q[j][l];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q[j] <= 1'b0;
        b_vld_q[j] <= 1'b0;
        c_vld_q[j] <= 1'b0;
      end else if (en_i) begin
        a_vld_q[j] <= in_vld[j];
        b_vld_q[j] <= a_vld_q[j];
        c_vld_q[j] <= b_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_th_q[j]   <= in_th[j];
        a_s2_q[j]   <= in_s2[j];
        a_side_q[j] <= in_side[j];
        b_th_q[j]   <= a_th_q[j];
        b_s2_q[j]   <= a_s2_q[j];
        b_p_q[j]    <= a_p_q[j];
        b_side_q[j] <= a_side_q[j];
        c_th_q[j]   <= b_th_q[j];
        c_s2_q[j]   <= b_s2_q[j];
        c_side_q[j] <= b_side_q[j];
        for (int l = 0; l < 2; l++) begin
          a_p_q[j][l]  <= p_t'((pa[l] + (67'd1 << 31)) >> 32);
          b_q0_q[j][l] <= 32'(pb[l] >> 34);
          c_t_q[j][l]  <= ONE - 33'(qq[l]);
        end
      end
    end
  end

  // final multiply by the angle, clamped to one
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      r_prod[l] = 66'(c_th_q[TT-1][l]) * 66'(c_t_q[TT-1][l]);
      r_rnd[l]  = 34'((r_prod[l] + (66'd1 << 31)) >> 32);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_side_q <= c_side_q[TT-1];
      for (int l = 0; l < 2; l++) begin
        r_sin_q[l] <= (r_rnd[l] > 34'(ONE)) ? ONE : th_t'(r_rnd[l]);
      end
    end
  end

  assign valid_o = r_vld_q;
  assign sin_o   = r_sin_q;
  assign side_o  = r_side_q;

endmodule

// File: rtl/g2lo_sqrt.sv
// Sine product and pipelined digit-by-digit square root of 1 - v^2.
module g2lo_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  g2lo_pkg::th_t [1:0]  sin_i,
  input  g2lo_pkg::side_t      side_i,
  output logic                 valid_o,
  output g2lo_pkg::th_t        root_o,
  output g2lo_pkg::th_t        v_o,
  output g2lo_pkg::side_t      side_o
);
  import g2lo_pkg::*;

  localparam int NQ = SQRT_STEPS;

  logic        v_vld_q, n_vld_q;
  th_t         v_q, n_v_q;
  logic [65:0] n_q;
  side_t       v_side_q, n_side_q;
  logic [65:0] v_prod;
  logic [33:0] v_rnd;

  logic [NQ-1:0] s_vld_q;
  th_t           s_root_q [NQ];
  logic [33:0]   s_rem_q  [NQ];
  logic [65:0]   s_n_q    [NQ];
  th_t           s_v_q    [NQ];
  side_t         s_side_q [NQ];

  logic          in_vld  [NQ];
  th_t           in_root [NQ];
  logic [33:0]   in_rem  [NQ];
  logic [65:0]   in_n    [NQ];
  th_t           in_v    [NQ];
  side_t         in_side [NQ];

  // v = cos(lat) * sin(dlon/2)
  assign v_prod = 66'(sin_i[0]) * 66'(sin_i[1]);
  assign v_rnd  = 34'((v_prod + (66'd1 << 31)) >> 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= 1'b0;
      n_vld_q <= 1'b0;
    end else if (en_i) begin
      v_vld_q <= valid_i;
      n_vld_q <= v_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q      <= (v_rnd > 34'(ONE)) ? ONE : th_t'(v_rnd);
      v_side_q <= side_i;
      n_q      <= 66'(ONE - v_q) * (66'(ONE) + 66'(v_q));
      n_v_q    <= v_q;
      n_side_q <= v_side_q;
    end
  end

  genvar i;
  for (i = 0; i < NQ; i++) begin : g_step
    localparam int B = NQ - 1 - i;

    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign in_vld[i]  = n_vld_q;
      assign in_root[i] = '0;
      assign in_rem[i]  = '0;
      assign in_n[i]    = n_q;
      assign in_v[i]    = n_v_q;
      assign in_side[i] = n_side_q;
    end else begin : g_next
      assign in_vld[i]  = s_vld_q[i-1];
      assign in_root[i] = s_root_q[i-1];
      assign in_rem[i]  = s_rem_q[i-1];
      assign in_n[i]    = s_n_q[i-1];
      assign in_v[i]    = s_v_q[i-1];
      assign in_side[i] = s_side_q[i-1];
    end

    // bring down the next pair of bits and try root*4+1
    assign cur   = {in_rem[i], in_n[i][2*B+1 -: 2]};
    assign trial = {1'b0, in_root[i], 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        s_vld_q[i] <= in_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_root_q[i] <= {in_root[i][31:0], ge};
        s_rem_q[i]  <= ge ? 34'(cur - trial) : 34'(cur);
        s_n_q[i]    <= in_n[i];
        s_v_q[i]    <= in_v[i];
        s_side_q[i] <= in_side[i];
      end
    end
  end

  assign valid_o = s_vld_q[NQ-1];
  assign root_o  = s_root_q[NQ-1];
  assign v_o     = s_v_q[NQ-1];
  assign side_o  = s_side_q[NQ-1];

endmodule

// File: rtl/g2lo_cordic.sv
// Vectoring CORDIC for the arcsine angle and scaling to the east span.
module g2lo_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  g2lo_pkg::th_t    root_i,
  input  g2lo_pkg::th_t    v_i,
  input  g2lo_pkg::side_t  side_i,
  output logic             valid_o,
  output logic [30:0]      east_span_o,
  output g2lo_pkg::side_t  side_o
);
  import g2lo_pkg::*;

  localparam int NC = CORDIC_STEPS;

  logic [NC-1:0]      c_vld_q;
  logic signed [36:0] c_x_q [NC];
  logic signed [36:0] c_y_q [NC];
  logic signed [36:0] c_z_q [NC];
  side_t              c_side_q [NC];

  logic               in_vld  [NC];
  logic signed [36:0] in_x    [NC];
  logic signed [36:0] in_y    [NC];
  logic signed [36:0] in_z    [NC];
  side_t              in_side [NC];

  logic               p_vld_q, o_vld_q;
  logic [38:0]        p_hi_q;
  logic [66:0]        p_lo_q;
  side_t              p_side_q, o_side_q;
  logic [30:0]        o_span_q;
  logic [34:0]        ang2;
  logic [39:0]        span;

  genvar i;
  for (i = 0; i < NC; i++) begin : g_step
    localparam th_t AT = atan_q(i);

    logic signed [36:0] dx;
    logic signed [36:0] dy;

    if (i == 0) begin : g_first
      assign in_vld[i]  = valid_i;
      assign in_x[i]    = $signed({4'b0, root_i});
      assign in_y[i]    = $signed({4'b0, v_i});
      assign in_z[i]    = '0;
      assign in_side[i] = side_i;
    end else begin : g_next
      assign in_vld[i]  = c_vld_q[i-1];
      assign in_x[i]    = c_x_q[i-1];
      assign in_y[i]    = c_y_q[i-1];
      assign in_z[i]    = c_z_q[i-1];
      assign in_side[i] = c_side_q[i-1];
    end

    assign dx = in_y[i] >>> i;
    assign dy = in_x[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_vld_q[i] <= 1'b0;
      end else if (en_i) begin
        c_vld_q[i] <= in_vld[i];
      end
    end

    // rotate toward y = 0, hold when y is already zero
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_side_q[i] <= in_side[i];
        if (in_y[i] > 0) begin
          c_x_q[i] <= in_x[i] + dx;
          c_y_q[i] <= in_y[i] - dy;
          c_z_q[i] <= in_z[i] + $signed({4'b0, AT});
        end else if (in_y[i] < 0) begin
          c_x_q[i] <= in_x[i] - dx;
          c_y_q[i] <= in_y[i] + dy;
          c_z_q[i] <= in_z[i] - $signed({4'b0, AT});
        end else begin
          c_x_q[i] <= in_x[i];
          c_y_q[i] <= in_y[i];
          c_z_q[i] <= in_z[i];
        end
      end
    end
  end

  // doubled angle, clamped at zero
  assign ang2 = c_z_q[NC-1][36] ? '0 : {c_z_q[NC-1][33:0], 1'b0};
  assign span = 40'(p_hi_q) + 40'((p_lo_q + (67'd1 << 31)) >> 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= c_vld_q[NC-1];
      o_vld_q <= p_vld_q;
    end
  end

  // times radius in 0.1 mm, rounded and saturated
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_hi_q   <= 39'(ang2) * 39'(RAD_HI);
      p_lo_q   <= 67'(ang2) * 67'(RAD_LO);
      p_side_q <= c_side_q[NC-1];
      o_span_q <= (span > 40'(SPAN_LIMIT)) ? SPAN_LIMIT : span[30:0];
      o_side_q <= p_side_q;
    end
  end

  assign valid_o     = o_vld_q;
  assign east_span_o = o_span_q;
  assign side_o      = o_side_q;

endmodule

// File: rtl/gps_to_local_offset.sv
// Top level: GPS step to local east/north target, fully pipelined.
//
//  port group   dir  tdata fields (low bit first)
//  s_axis_*     in   cur_lat, cur_lon, next_lat, next_lon, local_east, local_north
//  m_axis_*     out  target_east, target_north, east_span, north_span
//
// One transaction per cycle while the output is not stalled, through the
// front end, 13-term Horner sine, 33-step root, 33-step CORDIC and output
// register. Reset clears only valid bits. When the output register holds
// a transaction that is not taken, every stage holds, so nothing is lost.
module gps_to_local_offset (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // cur_lat[30:0], cur_lon[62:31], next_lat[93:63], next_lon[125:94],
  // local_east[157:126], local_north[189:158], zero pad
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // target_east[31:0], target_north[63:32], east_span[94:64],
  // north_span[125:95], zero pad
  output logic [127:0] m_axis_tdata_o
);
  import g2lo_pkg::*;

  logic        en;
  logic        fr_vld, sn_vld, sq_vld, cd_vld;
  th_t [1:0]   fr_th, sn_sin;
  th_t         sq_root, sq_v;
  side_t       fr_side, sn_side, sq_side, cd_side;
  logic [30:0] cd_east;

  logic               out_vld_q;
  logic signed [31:0] out_te_q, out_tn_q;
  logic [30:0]        out_es_q, out_ns_q;
  logic signed [33:0] te_sum, tn_sum;

  // whole pipeline advances unless the output transaction is stuck
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  g2lo_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid_i),
    .cur_lat_i     ($signed(s_axis_tdata_i[30:0])),
    .cur_lon_i     ($signed(s_axis_tdata_i[62:31])),
    .next_lat_i    ($signed(s_axis_tdata_i[93:63])),
    .next_lon_i    ($signed(s_axis_tdata_i[125:94])),
    .local_east_i  ($signed(s_axis_tdata_i[157:126])),
    .local_north_i ($signed(s_axis_tdata_i[189:158])),
    .valid_o       (fr_vld),
    .th_o          (fr_th),
    .side_o        (fr_side)
  );

  g2lo_sin u_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .th_i    (fr_th),
    .side_i  (fr_side),
    .valid_o (sn_vld),
    .sin_o   (sn_sin),
    .side_o  (sn_side)
  );

  g2lo_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sn_vld),
    .sin_i   (sn_sin),
    .side_i  (sn_side),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .v_o     (sq_v),
    .side_o  (sq_side)
  );

  g2lo_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (sq_vld),
    .root_i      (sq_root),
    .v_i         (sq_v),
    .side_i      (sq_side),
    .valid_o     (cd_vld),
    .east_span_o (cd_east),
    .side_o      (cd_side)
  );

  // add or subtract the spans
  always_comb begin
    if (cd_side.east_pos) begin
      te_sum = 34'(cd_side.local_east) + $signed({3'b0, cd_east});
    end else begin
      te_sum = 34'(cd_side.local_east) - $signed({3'b0, cd_east});
    end
    if (cd_side.north_pos) begin
      tn_sum = 34'(cd_side.local_north) + $signed({3'b0, cd_side.north_span});
    end else begin
      tn_sum = 34'(cd_side.local_north) - $signed({3'b0, cd_side.north_span});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= cd_vld;
    end
  end

  // output register with position saturation
  always_ff @(posedge clk_i) begin
    if (en) begin
      priority if (te_sum > 34'sd2000000000)       out_te_q <= 32'sd2000000000;
      else if (te_sum < -34'sd2000000000)          out_te_q <= -32'sd2000000000;
      else                                         out_te_q <= 32'(te_sum);
      priority if (tn_sum > 34'sd2000000000)       out_tn_q <= 32'sd2000000000;
      else if (tn_sum < -34'sd2000000000)          out_tn_q <= -32'sd2000000000;
      else                                         out_tn_q <= 32'(tn_sum);
      out_es_q <= cd_east;
      out_ns_q <= cd_side.north_span;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b0, out_ns_q, out_es_q, out_tn_q, out_te_q};

endmodule
